// ===== hw/rtl/drsm_pkg.sv =====
package drsm_pkg;

    localparam int RING_DEPTH_DEF   = 2048;
    localparam int CHUNK_FRAMES_DEF = 64;

    localparam int SAMPLE_W   = 16;
    localparam int SPACE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Request types
    localparam logic [1:0] REQ_PUSH_USB = 2'd0;
    localparam logic [1:0] REQ_PUSH_WL  = 2'd1;
    localparam logic [1:0] REQ_MIX      = 2'd2;

    // Result kinds
    localparam logic [1:0] RES_PUSH  = 2'd0;
    localparam logic [1:0] RES_FRAME = 2'd1;
    localparam logic [1:0] RES_SKIP  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIX_WIRELESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 2'd1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    typedef struct packed {
        logic full;
        logic ge2;
    } ring_stat_t;

    // Clamp a 17-bit sum to the 16-bit sample range.
    function automatic sample_t sat16(input logic signed [SAMPLE_W:0] s);
        sample_t r;
        if (s[SAMPLE_W] != s[SAMPLE_W-1])
        begin
            r = s[SAMPLE_W] ? sample_t'(16'sh8000) : sample_t'(16'sh7FFF);
        end
        else
        begin
            r = s[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/drsm_if.sv =====
interface drsm_in_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    drsm_pkg::sample_t               sample;
    logic                            batch_end;
    logic [drsm_pkg::SPACE_W-1:0]    dac_space;

    modport source (output valid, req_type, sample, batch_end, dac_space, input ready);
    modport sink   (input valid, req_type, sample, batch_end, dac_space, output ready);
endinterface

interface drsm_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic              accepted;
    drsm_pkg::sample_t left_out;
    drsm_pkg::sample_t right_out;
    logic              last;

    modport source (output valid, result_kind, accepted, left_out, right_out, last,
                    input ready);
    modport sink   (input valid, result_kind, accepted, left_out, right_out, last,
                    output ready);
endinterface

interface drsm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [drsm_pkg::CFG_IDX_W-1:0]    index;
    logic [drsm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/dual_ring_saturating_mixer_core.sv =====
// Dual ring saturating mixer.
//
// Channels: req takes one request per handshake: a USB push, a wireless
// push or a mix request. rsp returns the results of each request in order;
// the final result of a request carries last. cfg writes the two control
// registers (mix_wireless, output_enable) and is always ready; write it only
// while the block is idle.
// Sequencing: a push or a skipped mix request gives its one result on rsp
// through the output register. A mix request emits min(dac_space, CHUNK_FRAMES)
// frames, each through the states S_RD_L, S_RD_R and S_SUM_R: the two pops of
// each ring memory go through its single registered read port, and the
// saturating add follows. A new request is taken in the idle state only, so
// no new request is taken until every frame of a mix request is out.
// Stall: rsp holds its result until taken; one more finished result waits
// in a pending register while the sequencer holds.
// Reset: both rings are empty (store contents undefined), mix_wireless is 1,
// output_enable is 0, rsp is empty. batch_end has no effect.
module dual_ring_saturating_mixer_core #(
    parameter int RING_DEPTH   = drsm_pkg::RING_DEPTH_DEF,
    parameter int CHUNK_FRAMES = drsm_pkg::CHUNK_FRAMES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    drsm_in_if.sink        req,
    drsm_out_if.source     rsp,
    drsm_cfg_if.sink       cfg
);

    localparam int FW = $clog2(CHUNK_FRAMES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD_L  = 5'b00010,
        S_RD_R  = 5'b00100,
        S_SUM_R = 5'b01000,
        S_PUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic mix_wl_reg, mix_wl_next;
    logic out_en_reg, out_en_next;

    logic [FW-1:0] frames_left_reg, frames_left_next;
    drsm_pkg::sample_t left_reg, left_next;

    // Pending result, held while rsp is stalled
    logic [1:0]        pend_kind_reg, pend_kind_next;
    logic              pend_acc_reg, pend_acc_next;
    drsm_pkg::sample_t pend_left_reg, pend_left_next;
    drsm_pkg::sample_t pend_right_reg, pend_right_next;
    logic              pend_last_reg, pend_last_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic              out_acc_reg, out_acc_next;
    drsm_pkg::sample_t out_left_reg, out_left_next;
    drsm_pkg::sample_t out_right_reg, out_right_next;
    logic              out_last_reg, out_last_next;

    drsm_pkg::ring_ctrl_t usb_ctrl, wl_ctrl;
    drsm_pkg::ring_stat_t usb_stat, wl_stat;
    drsm_pkg::sample_t    usb_data, wl_data;

    logic              out_free;
    logic              emit;
    logic [1:0]        e_kind;
    logic              e_acc;
    drsm_pkg::sample_t e_left, e_right;
    logic              e_last;
    logic              skip;
    logic [FW-1:0]     frames;
    drsm_pkg::sample_t mix_sum;

    drsm_ring #(.DEPTH(RING_DEPTH)) u_usb_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (usb_ctrl),
        .push_data (req.sample),
        .stat      (usb_stat),
        .pop_data  (usb_data)
    );

    drsm_ring #(.DEPTH(RING_DEPTH)) u_wl_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (wl_ctrl),
        .push_data (req.sample),
        .stat      (wl_stat),
        .pop_data  (wl_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.left_out    = out_left_reg;
    assign rsp.right_out   = out_right_reg;
    assign rsp.last        = out_last_reg;

    // Config writes: only bit 0 counts, unknown indexes drop.
    always_comb
    begin
        mix_wl_next = mix_wl_reg;
        out_en_next = out_en_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                drsm_pkg::REG_MIX_WIRELESS:  mix_wl_next = cfg.data[0];
                drsm_pkg::REG_OUTPUT_ENABLE: out_en_next = cfg.data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        // Skip when output is off, no space, or no ring in the mix can fill a frame.
        skip = !out_en_reg || (req.dac_space == '0) ||
               (!usb_stat.ge2 && (!mix_wl_reg || !wl_stat.ge2));
        if (req.dac_space > drsm_pkg::SPACE_W'(CHUNK_FRAMES))
        begin
            frames = FW'(CHUNK_FRAMES);
        end
        else
        begin
            frames = FW'(req.dac_space);
        end
        // Sum whatever sample the rings returned this cycle.
        mix_sum = drsm_pkg::sat16({usb_data[drsm_pkg::SAMPLE_W-1], usb_data} +
                  (mix_wl_reg ? {wl_data[drsm_pkg::SAMPLE_W-1], wl_data} : '0));
    end

    always_comb
    begin
        state_next       = state_reg;
        frames_left_next = frames_left_reg;
        left_next        = left_reg;
        pend_kind_next   = pend_kind_reg;
        pend_acc_next    = pend_acc_reg;
        pend_left_next   = pend_left_reg;
        pend_right_next  = pend_right_reg;
        pend_last_next   = pend_last_reg;

        out_free       = !out_valid_reg || rsp.ready;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_kind_next  = out_kind_reg;
        out_acc_next   = out_acc_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_last_next  = out_last_reg;

        usb_ctrl = '0;
        wl_ctrl  = '0;

        emit    = 1'b0;
        e_kind  = drsm_pkg::RES_PUSH;
        e_acc   = 1'b0;
        e_left  = '0;
        e_right = '0;
        e_last  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.req_type)
                        drsm_pkg::REQ_PUSH_USB:
                        begin
                            usb_ctrl.push = 1'b1;
                            emit          = 1'b1;
                            e_acc         = !usb_stat.full;
                        end
                        drsm_pkg::REQ_PUSH_WL:
                        begin
                            wl_ctrl.push = 1'b1;
                            emit         = 1'b1;
                            e_acc        = !wl_stat.full;
                        end
                        drsm_pkg::REQ_MIX:
                        begin
                            if (skip)
                            begin
                                emit   = 1'b1;
                                e_kind = drsm_pkg::RES_SKIP;
                            end
                            else
                            begin
                                frames_left_next = frames;
                                state_next       = S_RD_L;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_L:
            begin
                // Issue the left pops.
                usb_ctrl.pop = 1'b1;
                wl_ctrl.pop  = mix_wl_reg;
                state_next   = S_RD_R;
            end
            S_RD_R:
            begin
                // Capture the left sum, issue the right pops.
                left_next    = mix_sum;
                usb_ctrl.pop = 1'b1;
                wl_ctrl.pop  = mix_wl_reg;
                state_next   = S_SUM_R;
            end
            S_SUM_R:
            begin
                emit             = 1'b1;
                e_kind           = drsm_pkg::RES_FRAME;
                e_left           = left_reg;
                e_right          = mix_sum;
                e_last           = (frames_left_reg == FW'(1));
                frames_left_next = frames_left_reg - 1'b1;
            end
            S_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_acc_next   = pend_acc_reg;
                    out_left_next  = pend_left_reg;
                    out_right_next = pend_right_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = pend_last_reg ? S_IDLE : S_RD_L;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the output register when free, else park the result and hold.
        if (emit)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_kind_next  = e_kind;
                out_acc_next   = e_acc;
                out_left_next  = e_left;
                out_right_next = e_right;
                out_last_next  = e_last;
                state_next     = e_last ? S_IDLE : S_RD_L;
            end
            else
            begin
                pend_kind_next  = e_kind;
                pend_acc_next   = e_acc;
                pend_left_next  = e_left;
                pend_right_next = e_right;
                pend_last_next  = e_last;
                state_next      = S_PUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mix_wl_reg    <= 1'b1;
            out_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mix_wl_reg    <= mix_wl_next;
            out_en_reg    <= out_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frames_left_reg <= frames_left_next;
        left_reg        <= left_next;
        pend_kind_reg   <= pend_kind_next;
        pend_acc_reg    <= pend_acc_next;
        pend_left_reg   <= pend_left_next;
        pend_right_reg  <= pend_right_next;
        pend_last_reg   <= pend_last_next;
        out_kind_reg    <= out_kind_next;
        out_acc_reg     <= out_acc_next;
        out_left_reg    <= out_left_next;
        out_right_reg   <= out_right_next;
        out_last_reg    <= out_last_next;
    end

endmodule

// ===== hw/rtl/drsm_ring.sv =====
module drsm_ring #(
    parameter int DEPTH = drsm_pkg::RING_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  drsm_pkg::ring_ctrl_t  ctrl,
    input  drsm_pkg::sample_t     push_data,
    output drsm_pkg::ring_stat_t  stat,
    output drsm_pkg::sample_t     pop_data
);

    localparam int AW = $clog2(DEPTH);

    drsm_pkg::sample_t mem [DEPTH];
    drsm_pkg::sample_t rd_data_reg;
    logic              hit_reg;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     wr_inc;
    logic [AW:0]       fill;
    logic              empty;

    always_comb
    begin
        wr_inc = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        empty  = (rd_ptr_reg == wr_ptr_reg);
        if (wr_ptr_reg >= rd_ptr_reg)
        begin
            fill = {1'b0, wr_ptr_reg} - {1'b0, rd_ptr_reg};
        end
        else
        begin
            fill = {1'b0, wr_ptr_reg} + (AW+1)'(DEPTH) - {1'b0, rd_ptr_reg};
        end
        stat.full = (wr_inc == rd_ptr_reg);
        stat.ge2  = (fill >= (AW+1)'(2));

        wr_ptr_next = wr_ptr_reg;
        if (ctrl.push && !stat.full)
        begin
            wr_ptr_next = wr_inc;
        end
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Pushes and pops never fall in the same cycle, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && !stat.full)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            if (ctrl.pop)
            begin
                hit_reg <= !empty;
            end
        end
    end

    // An empty ring pops as zero.
    assign pop_data = hit_reg ? rd_data_reg : '0;

endmodule

// ===== tb/tb_dual_ring_saturating_mixer_core.sv =====
`timescale 1ns / 1ps

module tb_dual_ring_saturating_mixer_core;

    typedef drsm_pkg::sample_t sample_t;

    localparam int RING_DEPTH   = drsm_pkg::RING_DEPTH_DEF;
    localparam int CHUNK_FRAMES = drsm_pkg::CHUNK_FRAMES_DEF;

    // Ring selectors for the local copy of the two FIFOs
    localparam int RING_USB = 0;
    localparam int RING_WL  = 1;

    // Request code that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Register indexes past the end of the register file
    localparam logic [drsm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [drsm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // Settle time before a register write; covers an ignored request in flight
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct {
        logic [1:0] kind;
        logic       acc;
        sample_t    left;
        sample_t    right;
        logic       last;
    } mixer_result_t;

    logic clk;
    logic rst_n;

    drsm_in_if  req_if ();
    drsm_out_if rsp_if ();
    drsm_cfg_if cfg_if ();

    dual_ring_saturating_mixer_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Local copy of the rings and control registers
    sample_t ring_mem [2][RING_DEPTH];
    int      rd_ptr [2];
    int      wr_ptr [2];
    logic    mix_wireless_q;
    logic    output_enable_q;

    // Frames, skips and push statuses still owed by the block, oldest first
    mixer_result_t mixer_result_q [$];

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;

    // Idle control shared by the request driver and the response receiver
    int idle_pct      = 0;
    bit long_hold_req = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Ring model
    // ------------------------------------------------------------------
    function automatic int ring_fill(int r);
        return (wr_ptr[r] + RING_DEPTH - rd_ptr[r]) % RING_DEPTH;
    endfunction

    function automatic logic ring_put(int r, sample_t v);
        int nx;
        nx = (wr_ptr[r] + 1) % RING_DEPTH;
        if (nx == rd_ptr[r])
        begin
            return 1'b0;
        end
        ring_mem[r][wr_ptr[r]] = v;
        wr_ptr[r] = nx;
        return 1'b1;
    endfunction

    // An empty ring yields silence and keeps its pointers
    function automatic int ring_take(int r);
        int v;
        if (rd_ptr[r] == wr_ptr[r])
        begin
            return 0;
        end
        v = ring_mem[r][rd_ptr[r]];
        rd_ptr[r] = (rd_ptr[r] + 1) % RING_DEPTH;
        return v;
    endfunction

    function automatic sample_t clip_to_sample(int v);
        if (v > 32767)
        begin
            return sample_t'(32767);
        end
        if (v < -32768)
        begin
            return sample_t'(-32768);
        end
        return sample_t'(v);
    endfunction

    // Advance the model by one accepted request and queue what it must produce
    task automatic predict_mixer_output(input logic [1:0] rt, input sample_t smp,
                                        input logic [drsm_pkg::SPACE_W-1:0] space);
        mixer_result_t r;
        int frames;
        int ch [2];
        r = '{kind: drsm_pkg::RES_PUSH, acc: 1'b0, left: '0, right: '0, last: 1'b1};
        case (rt)
            drsm_pkg::REQ_PUSH_USB:
            begin
                r.acc = ring_put(RING_USB, smp);
                mixer_result_q.push_back(r);
            end
            drsm_pkg::REQ_PUSH_WL:
            begin
                r.acc = ring_put(RING_WL, smp);
                mixer_result_q.push_back(r);
            end
            drsm_pkg::REQ_MIX:
            begin
                if (!output_enable_q || space == 0 ||
                    (ring_fill(RING_USB) < 2 &&
                     (!mix_wireless_q || ring_fill(RING_WL) < 2)))
                begin
                    r.kind = drsm_pkg::RES_SKIP;
                    mixer_result_q.push_back(r);
                end
                else
                begin
                    frames = (space > CHUNK_FRAMES) ? CHUNK_FRAMES : int'(space);
                    for (int f = 0; f < frames; f++)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            ch[c] = ring_take(RING_USB);
                            // Wireless ring stays untouched in USB-only mode
                            if (mix_wireless_q)
                            begin
                                ch[c] += ring_take(RING_WL);
                            end
                        end
                        r.kind  = drsm_pkg::RES_FRAME;
                        r.left  = clip_to_sample(ch[0]);
                        r.right = clip_to_sample(ch[1]);
                        r.last  = (f == frames - 1);
                        mixer_result_q.push_back(r);
                    end
                end
            end
            default:
            begin
                // Unused request code: no result, no state change
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then update the model.
    // Leave valid high on return so back-to-back requests need no gap.
    task automatic send_req(input logic [1:0] rt, input sample_t smp, input logic be,
                            input logic [drsm_pkg::SPACE_W-1:0] space);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= rt;
        req_if.sample    <= smp;
        req_if.batch_end <= be;
        req_if.dac_space <= space;
        do @(posedge clk); while (!req_if.ready);
        predict_mixer_output(rt, smp, space);
    endtask

    // Drop valid, drain every owed result, then let the sequencer settle
    task automatic wait_until_idle();
        req_if.valid <= 1'b0;
        while (mixer_result_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; only bit 0 of the data counts
    task automatic write_reg(input logic [drsm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [drsm_pkg::CFG_DATA_W-1:0] val);
        wait_until_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == drsm_pkg::REG_MIX_WIRELESS)
        begin
            mix_wireless_q = val[0];
        end
        else if (idx == drsm_pkg::REG_OUTPUT_ENABLE)
        begin
            output_enable_q = val[0];
        end
    endtask

    function automatic logic [drsm_pkg::SPACE_W-1:0] pick_space();
        if ($urandom_range(0, 9) == 0)
        begin
            return drsm_pkg::SPACE_W'($urandom_range(0, 65535));
        end
        return drsm_pkg::SPACE_W'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------
    // Response side: random stalls, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                // Stall now and load a random hold count
                hold_left = $urandom_range(0, 3);
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every taken result against the oldest owed one
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        mixer_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (mixer_result_q.size() == 0)
            begin
                $error("result_kind: expected none, actual %0d", rsp_if.result_kind);
                mismatch_cnt++;
            end
            else
            begin
                want = mixer_result_q.pop_front();
                check_field("result_kind", want.kind,  rsp_if.result_kind);
                check_field("accepted",    want.acc,   rsp_if.accepted);
                check_field("left_out",    want.left,  rsp_if.left_out);
                check_field("right_out",   want.right, rsp_if.right_out);
                check_field("last",        want.last,  rsp_if.last);
            end
        end
    end

    // Watchdog: stop a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Output disabled after reset, then enabled with too little in the rings or no room
    task automatic test_skip_conditions();
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd64);
        write_reg(drsm_pkg::REG_OUTPUT_ENABLE, 8'h01);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'h01);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd4);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(16'sh1234), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(-5), 1'b1, 16'hFFFF);
        // One sample in each ring: still skipped
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd1);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(7), 1'b1, 16'd0);
        // Enough data but no room at the converter
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd1);
    endtask

    // Drive sums past both rails
    task automatic test_saturation();
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(32767), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(-32768), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(32767), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(-32768), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd1);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(32767), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(-1), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(1), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(-32768), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd1);
    endtask

    // Rings run dry mid-request; then USB-only mode leaves wireless alone
    task automatic test_partial_rings();
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(100), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(-200), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd3);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(11), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(-12), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(300), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'(-400), 1'b1, 16'd0);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'h00);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'hFFFF);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'h01);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd2);
    endtask

    // Ignored request code, spare register indexes, wide register data
    task automatic test_unused_codes();
        send_req(REQ_UNUSED, sample_t'($urandom), 1'b1, 16'hFFFF);
        write_reg(REG_SPARE_A, 8'hFF);
        write_reg(REG_SPARE_B, 8'h00);
        write_reg(drsm_pkg::REG_OUTPUT_ENABLE, 8'hFE);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(1), 1'b0, 16'd0);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'(2), 1'b1, 16'd0);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd2);
        write_reg(drsm_pkg::REG_OUTPUT_ENABLE, 8'hFF);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'hAB);
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd2);
    endtask

    // Hold the response side off while requests keep coming, so input stalls
    task automatic test_backpressure();
        wait_until_idle();
        long_hold_req = 1;
        for (int i = 0; i < 16; i++)
        begin
            send_req((i % 2) ? drsm_pkg::REQ_PUSH_WL : drsm_pkg::REQ_PUSH_USB,
                     sample_t'($urandom), 1'b0, 16'd0);
        end
        send_req(drsm_pkg::REQ_MIX, sample_t'(0), 1'b0, 16'd8);
        send_req(drsm_pkg::REQ_PUSH_USB, sample_t'($urandom), 1'b1, 16'd0);
    endtask

    // Mostly stereo bursts followed by a mix request; some loose noise
    task automatic run_random_phase(input int n_items);
        int sent;
        int burst;
        logic [1:0] rt;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                rt = 2'($urandom_range(0, 3));
                send_req(rt, sample_t'($urandom), 1'($urandom), pick_space());
                if (rt != REQ_UNUSED)
                begin
                    sent++;
                end
            end
            else
            begin
                burst = 2 * $urandom_range(1, 6);
                for (int k = 0; k < burst; k++)
                begin
                    send_req(drsm_pkg::REQ_PUSH_USB, sample_t'($urandom), k == burst - 1,
                             16'($urandom));
                end
                sent += burst;
                if ($urandom_range(0, 3) != 0)
                begin
                    burst = 2 * $urandom_range(1, 6);
                    for (int k = 0; k < burst; k++)
                    begin
                        send_req(drsm_pkg::REQ_PUSH_WL, sample_t'($urandom),
                                 k == burst - 1, 16'($urandom));
                    end
                    sent += burst;
                end
                send_req(drsm_pkg::REQ_MIX, sample_t'($urandom), 1'($urandom),
                         pick_space());
                sent++;
            end
        end
    endtask

    task automatic test_random();
        idle_pct = 25;
        run_random_phase(15);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'h00);
        idle_pct = 0;
        run_random_phase(15);
        write_reg(drsm_pkg::REG_OUTPUT_ENABLE, 8'h00);
        idle_pct = 25;
        run_random_phase(10);
    endtask

    // Final stretch with no idling on either side
    task automatic test_quiet_tail();
        write_reg(drsm_pkg::REG_OUTPUT_ENABLE, 8'h01);
        write_reg(drsm_pkg::REG_MIX_WIRELESS, 8'h01);
        idle_pct = 0;
        run_random_phase(20);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = drsm_pkg::REQ_PUSH_USB;
        req_if.sample    = '0;
        req_if.batch_end = 1'b0;
        req_if.dac_space = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = drsm_pkg::REG_MIX_WIRELESS;
        cfg_if.data      = '0;
        rd_ptr           = '{0, 0};
        wr_ptr           = '{0, 0};
        mix_wireless_q   = 1'b1;
        output_enable_q  = 1'b0;

        // Hold reset, then release it once
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        test_skip_conditions();
        test_saturation();
        test_partial_rings();
        test_unused_codes();
        idle_pct = 5;
        test_backpressure();
        test_random();
        test_quiet_tail();

        // Drain everything owed, then watch for stray results
        wait_until_idle();
        repeat (50) @(posedge clk);
        if (mismatch_cnt == 0 && mixer_result_q.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
